// ===== rtl/tocs_pkg.sv =====
`timescale 1ns / 1ps

package tocs_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [7:0]  OP_NOP   = 8'd0;
    localparam logic [7:0]  OP_SET   = 8'd1;
    localparam logic [7:0]  OP_CLR   = 8'd2;
    localparam logic [7:0]  OP_DELAY = 8'd3;
    localparam logic [7:0]  OP_END   = 8'hFF;

    localparam logic [15:0] DEFAULT_PERIOD = 16'd1800;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  entry_index;
        logic [7:0]  entry_opcode;
        logic [15:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [7:0]  output_pins;
        logic        scan_ran;
        logic [15:0] delay_taken;
        logic [31:0] next_scan_time;
        logic [31:0] current_time;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] value;
    } entry_t;

endpackage

// ===== rtl/timed_output_command_sequencer.sv =====
`timescale 1ns / 1ps

// Timed output command sequencer. Each request is a command table write or one
// tick; each gives exactly one response. A write or a tick that does not hit the
// scan time goes from S_IDLE through S_DONE into the response register. A tick
// that starts a scan walks the table one entry per cycle through the single
// read port of the table memory, up to END, a nonzero DELAY or at most
// TABLE_DEPTH entries. A new request is taken once the previous one has reached
// the response register; the response waits there for rsp_ready, and the next
// response waits in S_DONE behind it. Table slots not yet written read as END.

module timed_output_command_sequencer #(
    parameter int TABLE_DEPTH = tocs_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tocs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tocs_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EXEC,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [7:0]              latch_reg, latch_next;
    logic [31:0]             now_reg, now_next;
    logic [31:0]             due_reg, due_next;
    logic [31:0]             start_reg, start_next;
    logic [15:0]             period_reg;
    logic                    ran_reg, ran_next;
    logic [15:0]             delay_reg, delay_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    tocs_pkg::rsp_t          rsp_reg, rsp_next;

    tocs_pkg::entry_t        mem [TABLE_DEPTH];
    tocs_pkg::entry_t        rd_data_reg;
    logic                    rd_valid_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        wr_addr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    logic [31:0]             idx_wide;
    logic                    wr_ok;
    logic [31:0]             now_inc;
    logic [31:0]             period_end;
    logic [PTR_W-1:0]        ptr_inc;
    tocs_pkg::entry_t        cur;

    assign idx_wide   = 32'(req.entry_index);
    assign wr_ok      = idx_wide < 32'(TABLE_DEPTH);
    assign wr_addr    = idx_wide[IDX_W-1:0];
    assign now_inc    = now_reg + 32'd1;
    assign period_end = start_reg + 32'(period_reg);
    assign ptr_inc    = ptr_reg + PTR_W'(1);
    assign cur        = rd_valid_reg ? rd_data_reg
                                     : tocs_pkg::entry_t'({tocs_pkg::OP_END, 16'd0});

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        latch_next     = latch_reg;
        now_next       = now_reg;
        due_next       = due_reg;
        start_next     = start_reg;
        ran_next       = ran_reg;
        delay_next     = delay_reg;
        valid_next     = valid_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ran_next   = 1'b0;
                    delay_next = 16'd0;
                    state_next = S_DONE;
                    if (req.req_type == tocs_pkg::REQ_WRITE)
                    begin
                        if (wr_ok)
                        begin
                            mem_we              = 1'b1;
                            valid_next[wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        now_next = now_inc;
                        if (now_inc == due_reg)
                        begin
                            ran_next   = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                if (ptr_reg == PTR_LAST)
                begin
                    due_next   = period_end;
                    start_next = period_end;
                    ptr_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (cur.opcode == tocs_pkg::OP_END)
                begin
                    due_next   = period_end;
                    start_next = period_end;
                    ptr_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    case (cur.opcode)
                        tocs_pkg::OP_SET: latch_next = latch_reg | cur.value[7:0];
                        tocs_pkg::OP_CLR: latch_next = latch_reg & ~cur.value[7:0];
                        default:          latch_next = latch_reg;
                    endcase
                    if (cur.opcode == tocs_pkg::OP_DELAY && cur.value != 16'd0)
                    begin
                        due_next   = due_reg + 32'(cur.value);
                        delay_next = cur.value;
                        state_next = S_DONE;
                    end
                    else if (ptr_inc == PTR_LAST)
                    begin
                        due_next   = period_end;
                        start_next = period_end;
                        ptr_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // prefetch next entry
                        rd_en   = 1'b1;
                        rd_addr = ptr_inc[IDX_W-1:0];
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.output_pins    = latch_reg;
                    rsp_next.scan_ran       = ran_reg;
                    rsp_next.delay_taken    = delay_reg;
                    rsp_next.next_scan_time = due_reg;
                    rsp_next.current_time   = now_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= tocs_pkg::entry_t'({req.entry_opcode, req.entry_value});
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            latch_reg     <= 8'd0;
            now_reg       <= 32'd0;
            due_reg       <= 32'd1;
            start_reg     <= 32'd1;
            period_reg    <= tocs_pkg::DEFAULT_PERIOD;
            ran_reg       <= 1'b0;
            delay_reg     <= 16'd0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            latch_reg     <= latch_next;
            now_reg       <= now_next;
            due_reg       <= due_next;
            start_reg     <= start_next;
            ran_reg       <= ran_next;
            delay_reg     <= delay_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("command pointer past table end");

    a_exec_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(rd_en))
        else $error("entry evaluated without a read the cycle before");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.req_type == tocs_pkg::REQ_WRITE)
        |=> state_reg == S_DONE)
        else $error("table write did not go straight to response");

    a_delay_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.scan_ran) |-> rsp.delay_taken == 16'd0)
        else $error("delay reported without a scan");

endmodule
